// ===== hw/rtl/hrf_pkg.sv =====
// shared types, constants and helper functions of the haversine radius filter
`default_nettype none

package hrf_pkg;

    // default number of cordic iterations
    localparam int CORDIC_STEPS_DEF = 16;

    // field widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 23;
    localparam int CFG_W  = 25;
    localparam int IDX_W  = 2;
    localparam int ANG_W  = 34;
    localparam int PROD_W = 68;
    localparam int ROOT_W = 31;
    localparam int DEG_W  = 27;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_REF_LAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_REF_LON = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS  = 2'd2;

    // reset value of the match radius, 10 km in q8
    localparam logic [DIST_W-1:0] RADIUS_RST = 23'd2560;

    // fixed-point constants
    localparam logic signed [ANG_W-1:0] PI_Q30   = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] KINV_Q30 = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] TWO_R_KM = 34'sd12742;
    localparam logic [ROOT_W-1:0]       ONE_Q30  = 31'd1073741824;
    localparam logic signed [DEG_W-1:0] DEG90_Q16  = 27'sd5898240;
    localparam logic signed [DEG_W-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [DEG_W-1:0] DEG360_Q16 = 27'sd23592960;
    localparam logic [23:0]             DIST_MAX   = 24'd5124096;

    // rounding terms for the degree to radian scaling (half the divisor)
    localparam logic [56:0] HALF_DEN180 = 57'd5898240;
    localparam logic [56:0] HALF_DEN360 = 57'd11796480;
    localparam logic [6:0]  DIV_K       = 7'd45;

    // datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_PREP  = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_ROT   = 4'd5;
    localparam logic [3:0] OP_TRIG  = 4'd6;
    localparam logic [3:0] OP_KEEP  = 4'd7;
    localparam logic [3:0] OP_SUMA  = 4'd8;
    localparam logic [3:0] OP_ROOT  = 4'd9;
    localparam logic [3:0] OP_KEEPR = 4'd10;
    localparam logic [3:0] OP_VEC   = 4'd11;
    localparam logic [3:0] OP_DIST  = 4'd12;

    // angle selects (prep and trig)
    localparam logic [2:0] AS_DLAT = 3'd0;
    localparam logic [2:0] AS_DLON = 3'd1;
    localparam logic [2:0] AS_LAT1 = 3'd2;
    localparam logic [2:0] AS_LAT2 = 3'd3;

    // multiplier operand selects
    localparam logic [2:0] MS_PI   = 3'd0;
    localparam logic [2:0] MS_S1   = 3'd1;
    localparam logic [2:0] MS_CC   = 3'd2;
    localparam logic [2:0] MS_S2   = 3'd3;
    localparam logic [2:0] MS_A2   = 3'd4;
    localparam logic [2:0] MS_DIST = 3'd5;

    // product destinations
    localparam logic [2:0] KS_T1 = 3'd0;
    localparam logic [2:0] KS_CC = 3'd1;
    localparam logic [2:0] KS_T2 = 3'd2;
    localparam logic [2:0] KS_T3 = 3'd3;

    // root selects
    localparam logic [2:0] RS_COMP = 3'd0;
    localparam logic [2:0] RS_A    = 3'd1;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] sel;
    } hrf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rot_done;
        logic root_done;
    } hrf_stat_t;

    // wrap a degree difference into (-180, 180]
    function automatic logic signed [DEG_W-1:0] wrap180(input logic signed [DEG_W-1:0] d);
        logic signed [DEG_W-1:0] r;
        r = d;
        if (r > DEG180_Q16) r = r - DEG360_Q16;
        if (r > DEG180_Q16) r = r - DEG360_Q16;
        if (r <= -DEG180_Q16) r = r + DEG360_Q16;
        if (r <= -DEG180_Q16) r = r + DEG360_Q16;
        return r;
    endfunction

    // arctangent of 2^-i in q30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            5'd24:   v = 34'sd64;
            5'd25:   v = 34'sd32;
            5'd26:   v = 34'sd16;
            5'd27:   v = 34'sd8;
            5'd28:   v = 34'sd4;
            5'd29:   v = 34'sd2;
            5'd30:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrf_cordic.sv =====
// iterative cordic unit, rotation and vectoring, one step per cycle
`default_nettype none

module hrf_cordic
    import hrf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic                    vec,
    input  wire logic signed [ANG_W-1:0] x0,
    input  wire logic signed [ANG_W-1:0] y0,
    input  wire logic signed [ANG_W-1:0] z0,
    output logic                         done,
    output logic signed [ANG_W-1:0]      x,
    output logic signed [ANG_W-1:0]      y,
    output logic signed [ANG_W-1:0]      z
);

    localparam int CW = $clog2(CORDIC_STEPS + 1);
    localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

    logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
    logic signed [ANG_W-1:0] x_next, y_next, z_next;
    logic signed [ANG_W-1:0] xs, ys, at;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg, done_reg, vec_reg, dir;

    // one micro-rotation
    always_comb begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        at  = atan_q30(5'(cnt_reg));
        dir = vec_reg ? y_reg[ANG_W-1] : ~z_reg[ANG_W-1];
        if (dir) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) busy_reg <= 1'b0;
            end
        end
    end

    // vector registers
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= vec;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hrf_root.sv =====
// bit-serial integer square root of a q30 value, one result bit per cycle
`default_nettype none

module hrf_root
    import hrf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ROOT_W-1:0] v,
    output logic                   done,
    output logic [ROOT_W-1:0]      q
);

    localparam int ROOT_STEPS = 32;
    localparam logic [4:0] LAST = 5'(ROOT_STEPS - 1);

    logic [63:0] n_reg, r_reg, bit_w, trial;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;

    // trial subtraction
    always_comb begin
        bit_w = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        trial = r_reg + bit_w;
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) busy_reg <= 1'b0;
            end
        end
    end

    // remainder and root
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= 64'(v) << 30;
            r_reg <= '0;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_w;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign q    = r_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/hrf_datapath.sv =====
// datapath: config registers, angle scaling, shared multiplier, cordic, roots, result word
`default_nettype none

module hrf_datapath
    import hrf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire hrf_cmd_t               cmd,
    output hrf_stat_t                   stat,
    input  wire logic signed [LAT_W-1:0] s_item_latitude,
    input  wire logic signed [LON_W-1:0] s_item_longitude,
    input  wire logic                   s_last_item,
    input  wire logic                   cfg_wr,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output logic [DIST_W-1:0]           m_distance_km,
    output logic                        m_within_radius,
    output logic                        m_none_found,
    output logic                        m_pass_end
);

    // configuration and item registers
    logic signed [LAT_W-1:0] lat1_reg, lat2_reg;
    logic signed [LON_W-1:0] lon1_reg, lon2_reg;
    logic [DIST_W-1:0]       radius_reg;
    logic                    last_reg, match_seen_reg;

    // angle preparation
    logic signed [DEG_W-1:0] prep_d, prep_w, prep_f;
    logic                    prep_cos, prep_neg;
    logic [23:0]             mag_reg;
    logic                    sgn_reg, cneg_reg, half_reg;

    // multiplier
    logic signed [ANG_W-1:0]  mul_a, mul_b, ang;
    logic signed [PROD_W-1:0] prod_reg;

    // constant divider
    logic [56:0] div_n;
    logic [39:0] div_t, div_w_reg, div_w_next;
    logic [5:0]  div_r_reg, div_r_next;
    logic [6:0]  div_r7;
    logic [3:0]  div_cnt_reg;
    logic        div_busy_reg, div_done_reg;
    logic signed [ANG_W-1:0] zq, rot_z;

    // trig and product results
    logic signed [ANG_W-1:0] sin1_reg, sin2_reg, cos1_reg, cos2_reg;
    logic signed [ANG_W-1:0] t1_reg, cc_reg, t2_reg, t3_reg, keep_v;
    logic signed [ANG_W:0]   a_sum;
    logic [ROOT_W-1:0]       a_reg, xr_reg, yr_reg, root_v, root_q;

    // cordic and root units
    logic                    cor_start, cor_vec, cor_done, root_done;
    logic signed [ANG_W-1:0] cx0, cy0, cz0, cx, cy, cz;

    // result
    logic [47:0]       dsum;
    logic [25:0]       dfull;
    logic [DIST_W-1:0] dist_v;
    logic              in_radius;
    logic [DIST_W-1:0] dist_reg;
    logic              within_reg, none_reg, pend_reg;

    localparam logic [3:0] DIV_LAST = 4'd9;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat1_reg   <= '0;
            lon1_reg   <= '0;
            radius_reg <= RADIUS_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_REF_LAT: lat1_reg   <= cfg_data[LAT_W-1:0];
                REG_REF_LON: lon1_reg   <= cfg_data[LON_W-1:0];
                REG_RADIUS:  radius_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            lat2_reg <= s_item_latitude;
            lon2_reg <= s_item_longitude;
            last_reg <= s_last_item;
        end
    end

    // wrap, fold and take the magnitude of the selected angle
    always_comb begin
        case (cmd.sel)
            AS_DLAT: prep_d = DEG_W'(lat2_reg) - DEG_W'(lat1_reg);
            AS_DLON: prep_d = DEG_W'(lon2_reg) - DEG_W'(lon1_reg);
            AS_LAT1: prep_d = DEG_W'(lat1_reg);
            AS_LAT2: prep_d = DEG_W'(lat2_reg);
            default: prep_d = '0;
        endcase
        prep_cos = (cmd.sel == AS_LAT1) || (cmd.sel == AS_LAT2);
        prep_w   = wrap180(prep_d);
        prep_neg = 1'b0;
        prep_f   = prep_w;
        if (prep_cos && (prep_w > DEG90_Q16)) begin
            prep_f   = DEG180_Q16 - prep_w;
            prep_neg = 1'b1;
        end else if (prep_cos && (prep_w < -DEG90_Q16)) begin
            prep_f   = -DEG180_Q16 - prep_w;
            prep_neg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PREP) begin
            mag_reg  <= prep_f[DEG_W-1] ? 24'(-prep_f) : 24'(prep_f);
            sgn_reg  <= prep_f[DEG_W-1];
            cneg_reg <= prep_neg;
            half_reg <= ~prep_cos;
        end
    end

    // shared multiplier operand select
    always_comb begin
        ang = cz[ANG_W-1] ? '0 : cz;
        case (cmd.sel)
            MS_PI:   begin mul_a = {10'd0, mag_reg}; mul_b = PI_Q30;   end
            MS_S1:   begin mul_a = sin1_reg;         mul_b = sin1_reg; end
            MS_CC:   begin mul_a = cos1_reg;         mul_b = cos2_reg; end
            MS_S2:   begin mul_a = sin2_reg;         mul_b = sin2_reg; end
            MS_A2:   begin mul_a = cc_reg;           mul_b = t2_reg;   end
            MS_DIST: begin mul_a = ang;              mul_b = TWO_R_KM; end
            default: begin mul_a = '0;               mul_b = '0;       end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_MUL) prod_reg <= mul_a * mul_b;
    end

    // divide by 45 after the power-of-two part of the divisor, four bits a cycle
    always_comb begin
        div_n      = prod_reg[56:0] + (half_reg ? HALF_DEN360 : HALF_DEN180);
        div_t      = half_reg ? 40'(div_n >> 19) : 40'(div_n >> 18);
        div_w_next = div_w_reg;
        div_r_next = div_r_reg;
        div_r7     = '0;
        for (int j = 0; j < 4; j++) begin
            div_r7     = {div_r_next, div_w_next[39]};
            div_w_next = {div_w_next[38:0], (div_r7 >= DIV_K)};
            div_r_next = (div_r7 >= DIV_K) ? 6'(div_r7 - DIV_K) : div_r7[5:0];
        end
        zq    = {1'b0, div_w_reg[ANG_W-2:0]};
        rot_z = sgn_reg ? -zq : zq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            div_done_reg <= div_busy_reg && (div_cnt_reg == DIV_LAST);
            if (cmd.op == OP_DIV) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DIV) begin
            div_w_reg <= div_t;
            div_r_reg <= '0;
        end else if (div_busy_reg) begin
            div_w_reg <= div_w_next;
            div_r_reg <= div_r_next;
        end
    end

    // cordic start vector
    assign cor_start = (cmd.op == OP_ROT) || (cmd.op == OP_VEC);
    assign cor_vec   = (cmd.op == OP_VEC);
    assign cx0       = cor_vec ? {3'b000, xr_reg} : KINV_Q30;
    assign cy0       = cor_vec ? {3'b000, yr_reg} : '0;
    assign cz0       = cor_vec ? '0 : rot_z;

    hrf_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cor_start),
        .vec    (cor_vec),
        .x0     (cx0),
        .y0     (cy0),
        .z0     (cz0),
        .done   (cor_done),
        .x      (cx),
        .y      (cy),
        .z      (cz)
    );

    // sines and cosines
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_TRIG) begin
            case (cmd.sel)
                AS_DLAT: sin1_reg <= cy;
                AS_DLON: sin2_reg <= cy;
                AS_LAT1: cos1_reg <= cneg_reg ? -cx : cx;
                AS_LAT2: cos2_reg <= cneg_reg ? -cx : cx;
                default: ;
            endcase
        end
    end

    // products back to q30
    assign keep_v = ANG_W'(prod_reg >>> 30);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_KEEP) begin
            case (cmd.sel)
                KS_T1:   t1_reg <= keep_v;
                KS_CC:   cc_reg <= keep_v;
                KS_T2:   t2_reg <= keep_v;
                KS_T3:   t3_reg <= keep_v;
                default: ;
            endcase
        end
    end

    // haversine term, clamped to [0, 1]
    assign a_sum = (ANG_W+1)'(t1_reg) + (ANG_W+1)'(t3_reg);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_SUMA) begin
            if (a_sum[ANG_W]) a_reg <= '0;
            else if (a_sum > (ANG_W+1)'(ONE_Q30)) a_reg <= ONE_Q30;
            else a_reg <= a_sum[ROOT_W-1:0];
        end
    end

    // square roots of 1 - a and a
    assign root_v = (cmd.sel == RS_A) ? a_reg : ONE_Q30 - a_reg;

    hrf_root u_root (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.op == OP_ROOT),
        .v      (root_v),
        .done   (root_done),
        .q      (root_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_KEEPR) begin
            case (cmd.sel)
                RS_COMP: xr_reg <= root_q;
                RS_A:    yr_reg <= root_q;
                default: ;
            endcase
        end
    end

    // distance rounding, saturation and match flag
    always_comb begin
        dsum      = prod_reg[47:0] + 48'd2097152;
        dfull     = 26'(dsum >> 22);
        dist_v    = (dfull > 26'(DIST_MAX)) ? DIST_MAX[DIST_W-1:0] : dfull[DIST_W-1:0];
        in_radius = (dist_v <= radius_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_seen_reg <= 1'b0;
        end else if (cmd.op == OP_DIST) begin
            if (last_reg) match_seen_reg <= 1'b0;
            else if (in_radius) match_seen_reg <= 1'b1;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DIST) begin
            dist_reg   <= dist_v;
            within_reg <= in_radius;
            none_reg   <= last_reg && !(match_seen_reg || in_radius);
            pend_reg   <= last_reg;
        end
    end

    assign stat.div_done  = div_done_reg;
    assign stat.rot_done  = cor_done;
    assign stat.root_done = root_done;

    assign m_distance_km   = dist_reg;
    assign m_within_radius = within_reg;
    assign m_none_found    = none_reg;
    assign m_pass_end      = pend_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hrf_ctrl.sv =====
// controller: sequences the datapath for one word and runs both handshakes
`default_nettype none

module hrf_ctrl
    import hrf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire hrf_stat_t stat,
    output hrf_cmd_t       cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_PREP   = 5'd1;
    localparam logic [4:0] ST_MULPI  = 5'd2;
    localparam logic [4:0] ST_DIVGO  = 5'd3;
    localparam logic [4:0] ST_DIVW   = 5'd4;
    localparam logic [4:0] ST_ROTGO  = 5'd5;
    localparam logic [4:0] ST_ROTW   = 5'd6;
    localparam logic [4:0] ST_TRIG   = 5'd7;
    localparam logic [4:0] ST_MUL    = 5'd8;
    localparam logic [4:0] ST_KEEP   = 5'd9;
    localparam logic [4:0] ST_SUMA   = 5'd10;
    localparam logic [4:0] ST_RTGO   = 5'd11;
    localparam logic [4:0] ST_RTW    = 5'd12;
    localparam logic [4:0] ST_RTKEEP = 5'd13;
    localparam logic [4:0] ST_VGO    = 5'd14;
    localparam logic [4:0] ST_VW     = 5'd15;
    localparam logic [4:0] ST_MD     = 5'd16;
    localparam logic [4:0] ST_OUT    = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;

    // next state and command
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        cmd.op         = OP_NOP;
        cmd.sel        = {1'b0, k_reg};
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    k_next     = 2'd0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                state_next = ST_MULPI;
            end
            ST_MULPI: begin
                cmd.op     = OP_MUL;
                cmd.sel    = MS_PI;
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.op     = OP_DIV;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (stat.div_done) state_next = ST_ROTGO;
            end
            ST_ROTGO: begin
                cmd.op     = OP_ROT;
                state_next = ST_ROTW;
            end
            ST_ROTW: begin
                if (stat.rot_done) state_next = ST_TRIG;
            end
            ST_TRIG: begin
                cmd.op = OP_TRIG;
                k_next = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? ST_MUL : ST_PREP;
            end
            ST_MUL: begin
                cmd.op     = OP_MUL;
                cmd.sel    = {1'b0, k_reg} + MS_S1;
                state_next = ST_KEEP;
            end
            ST_KEEP: begin
                cmd.op = OP_KEEP;
                k_next = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? ST_SUMA : ST_MUL;
            end
            ST_SUMA: begin
                cmd.op     = OP_SUMA;
                k_next     = 2'd0;
                state_next = ST_RTGO;
            end
            ST_RTGO: begin
                cmd.op     = OP_ROOT;
                state_next = ST_RTW;
            end
            ST_RTW: begin
                if (stat.root_done) state_next = ST_RTKEEP;
            end
            ST_RTKEEP: begin
                cmd.op = OP_KEEPR;
                k_next = k_reg + 1'b1;
                state_next = (k_reg == 2'd1) ? ST_VGO : ST_RTGO;
            end
            ST_VGO: begin
                cmd.op     = OP_VEC;
                state_next = ST_VW;
            end
            ST_VW: begin
                if (stat.rot_done) state_next = ST_MD;
            end
            ST_MD: begin
                cmd.op     = OP_MUL;
                cmd.sel    = MS_DIST;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // result register free or emptied this cycle
                if (!out_valid_reg || m_ready) begin
                    cmd.op         = OP_DIST;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/haversine_radius_filter_core.sv =====
// top level of the haversine radius filter
// Use: each input word is one stored point (latitude and longitude in degrees,
// q16) plus a last-of-pass flag, taken on s_valid && s_ready. Each word gives
// exactly one result word on the m_ channel: great-circle distance to the
// reference point in km q8, a within-radius flag, the pass-end copy and, on
// the last word of a pass, the no-match flag.
// The reference point and match radius are written through the cfg_ channel
// (index 0 latitude, 1 longitude, 2 radius); cfg_ready is always high and
// writes belong between passes while the block is idle.
// One word is in work at a time. The time per word is set by the single
// shared cordic unit (five runs), the divide-by-45 angle scaling (four
// angles) and the bit-serial square root (run twice).
// The result sits in an output register; a new word is accepted while it
// waits, and a stalled receiver only holds the block at the final write-back.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid,
// the pass match flag and restores the registers to 0, 0 and 10 km.
`default_nettype none

module haversine_radius_filter_core
    import hrf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [LAT_W-1:0] s_item_latitude,
    input  wire logic signed [LON_W-1:0] s_item_longitude,
    input  wire logic                    s_last_item,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [DIST_W-1:0]            m_distance_km,
    output logic                         m_within_radius,
    output logic                         m_none_found,
    output logic                         m_pass_end,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    hrf_cmd_t  cmd;
    hrf_stat_t stat;
    logic      cfg_wr;

    // register writes complete in the cycle they are offered
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    hrf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    hrf_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_item_latitude (s_item_latitude),
        .s_item_longitude(s_item_longitude),
        .s_last_item     (s_last_item),
        .cfg_wr          (cfg_wr),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_distance_km   (m_distance_km),
        .m_within_radius (m_within_radius),
        .m_none_found    (m_none_found),
        .m_pass_end      (m_pass_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/hrf_checker.sv =====
// port-level checker of the haversine radius filter and its bind
`default_nettype none

module hrf_checker
    import hrf_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [DIST_W-1:0] m_distance_km,
    input wire logic              m_within_radius,
    input wire logic              m_none_found,
    input wire logic              m_pass_end
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_km)
            && $stable(m_within_radius) && $stable(m_none_found) && $stable(m_pass_end))
    else $error("result word changed while stalled");

    // distance saturates at half the circumference
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (24'(m_distance_km) <= DIST_MAX))
    else $error("distance above saturation limit");

    // no-match only on the last word of a pass, never with a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_none_found |-> m_pass_end && !m_within_radius)
    else $error("no-match flag out of place");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
    else $error("result valid after reset");

endmodule

bind haversine_radius_filter_core hrf_checker u_hrf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_distance_km  (m_distance_km),
    .m_within_radius(m_within_radius),
    .m_none_found   (m_none_found),
    .m_pass_end     (m_pass_end)
);

`default_nettype wire

// ===== test/hrf_result_checker.sv =====
// result checker for the haversine radius filter: predicts each result word and compares
`timescale 1ns / 1ps

module hrf_result_checker
    import hrf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire logic signed [LAT_W-1:0] s_item_latitude,
    input  wire logic signed [LON_W-1:0] s_item_longitude,
    input  wire logic                    s_last_item,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire logic [DIST_W-1:0]       m_distance_km,
    input  wire logic                    m_within_radius,
    input  wire logic                    m_none_found,
    input  wire logic                    m_pass_end,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    output int                           fail_count,
    output int                           words_waiting,
    output int                           words_checked
);

    localparam longint PI_FX    = 64'sd3373259426;
    localparam longint KINV_FX  = 64'sd652032874;
    localparam longint ONE_FX   = 64'sd1073741824;
    localparam longint D90      = 64'sd5898240;
    localparam longint D180     = 64'sd11796480;
    localparam longint D360     = 64'sd23592960;
    localparam longint DIAM_KM  = 64'sd12742;
    localparam longint DIST_TOP = 64'sd5124096;

    typedef struct {
        logic [DIST_W-1:0] dist_km;
        logic              in_radius;
        logic              none;
        logic              pass_end;
    } filter_word_t;

    filter_word_t expected_words[$];

    longint arctan_q30[32];
    logic signed [LAT_W-1:0] ref_lat;
    logic signed [LON_W-1:0] ref_lon;
    logic [DIST_W-1:0]       radius_q8;
    logic                    pass_matched;

    initial begin
        arctan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                       16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                       131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                       128, 64, 32, 16, 8, 4, 2, 1, 0};
    end

    function automatic int iterations();
        return CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
    endfunction

    function automatic longint wrap_deg(longint d);
        longint r;
        r = ((d % D360) + D360) % D360;
        if (r > D180) r -= D360;
        return r;
    endfunction

    // degrees q16 to radians q30, rounded half away from zero
    function automatic longint to_radians(longint deg, longint den);
        longint unsigned mag, q;
        mag = deg < 0 ? -deg : deg;
        q = (mag * PI_FX + den / 2) / den;
        return deg < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic void rotate(longint z, output longint c, output longint s);
        longint x, y, nx;
        x = KINV_FX;
        y = 0;
        for (int i = 0; i < iterations(); i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q30[i];
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, nx;
        z = 0;
        for (int i = 0; i < iterations(); i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q30[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q30[i];
            end
            x = nx;
        end
        return z < 0 ? 0 : z;
    endfunction

    // cosine of a latitude, folded into [-90, 90] first
    function automatic longint lat_cosine(longint lat);
        longint r, c, s;
        logic   flip;
        r = wrap_deg(lat);
        flip = 1'b0;
        if (r > D90) begin
            r = D180 - r;
            flip = 1'b1;
        end else if (r < -D90) begin
            r = -D180 - r;
            flip = 1'b1;
        end
        rotate(to_radians(r, D180), c, s);
        return flip ? -c : c;
    endfunction

    function automatic longint half_sine(longint d);
        longint c, s;
        rotate(to_radians(wrap_deg(d), D360), c, s);
        return s;
    endfunction

    function automatic longint sqrt_q30(longint v);
        longint unsigned n, r, b;
        n = longint'(v) << 30;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // haversine distance in km q8 between the reference and one point
    function automatic longint great_circle_q8(longint lat2, longint lon2);
        longint s1, s2, cc, a, ang, dist_q8;
        s1 = half_sine(lat2 - longint'(ref_lat));
        s2 = half_sine(lon2 - longint'(ref_lon));
        cc = (lat_cosine(longint'(ref_lat)) * lat_cosine(lat2)) >>> 30;
        a = ((s1 * s1) >>> 30) + ((cc * ((s2 * s2) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > ONE_FX) a = ONE_FX;
        ang = vector_angle(sqrt_q30(ONE_FX - a), sqrt_q30(a));
        dist_q8 = (DIAM_KM * ang + (64'sd1 <<< 21)) >>> 22;
        if (dist_q8 > DIST_TOP) dist_q8 = DIST_TOP;
        return dist_q8;
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        $display("mismatch on result word %0d: %s expected %0d got %0d",
                 words_checked, field, want, got);
        fail_count++;
    endtask

    assign words_waiting = expected_words.size();

    always @(posedge aclk) begin
        filter_word_t w;
        longint d;
        if (!aresetn) begin
            ref_lat      <= '0;
            ref_lon      <= '0;
            radius_q8    <= RADIUS_RST;
            pass_matched = 1'b0;
            fail_count   = 0;
            words_checked <= 0;
            expected_words.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REF_LAT: ref_lat   <= cfg_data[LAT_W-1:0];
                    REG_REF_LON: ref_lon   <= cfg_data[LON_W-1:0];
                    REG_RADIUS:  radius_q8 <= cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            // predict one result per accepted point
            if (s_valid && s_ready) begin
                d = great_circle_q8(longint'(s_item_latitude), longint'(s_item_longitude));
                w.dist_km = d[DIST_W-1:0];
                w.in_radius = d <= longint'(radius_q8);
                w.pass_end = s_last_item;
                w.none = 1'b0;
                if (s_last_item) begin
                    w.none = !(pass_matched || w.in_radius);
                    pass_matched = 1'b0;
                end else if (w.in_radius) begin
                    pass_matched = 1'b1;
                end
                expected_words.push_back(w);
            end
            // compare against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("result word %0d arrived with nothing expected", words_checked);
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    if (m_distance_km !== w.dist_km)
                        report_mismatch("distance_km", w.dist_km, m_distance_km);
                    if (m_within_radius !== w.in_radius)
                        report_mismatch("within_radius", w.in_radius, m_within_radius);
                    if (m_none_found !== w.none)
                        report_mismatch("none_found", w.none, m_none_found);
                    if (m_pass_end !== w.pass_end)
                        report_mismatch("pass_end", w.pass_end, m_pass_end);
                end
                words_checked <= words_checked + 1;
            end
        end
    end

endmodule

// ===== test/tb_haversine_radius_filter_core.sv =====
// testbench top of the haversine radius filter: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module tb_haversine_radius_filter_core
    import hrf_pkg::*;
();

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int  PHASE_WORDS = 460;
    localparam int  LATENCY     = 5 * CORDIC_STEPS_DEF + 152;
    localparam longint CYCLE_LIMIT = 3000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [LAT_W-1:0] s_item_latitude = '0;
    logic signed [LON_W-1:0] s_item_longitude = '0;
    logic s_last_item = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DIST_W-1:0] m_distance_km;
    logic m_within_radius, m_none_found, m_pass_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    int fail_count, words_waiting, words_checked;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int points_sent = 0;
    int passes_sent = 0;
    longint cycle_count = 0;
    logic signed [LAT_W-1:0] cur_ref_lat = '0;
    logic signed [LON_W-1:0] cur_ref_lon = '0;

    haversine_radius_filter_core DUT (.*);

    hrf_result_checker u_checker (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    // run time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                              logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item_latitude <= lat;
        s_item_longitude <= lon;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        points_sent++;
        if (last) passes_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_waiting != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_REF_LAT) cur_ref_lat = value[LAT_W-1:0];
        if (idx == REG_REF_LON) cur_ref_lon = value[LON_W-1:0];
    endtask

    task automatic set_reference(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                                 logic [DIST_W-1:0] radius);
        write_reg(REG_REF_LAT, CFG_W'(lat));
        write_reg(REG_REF_LON, CFG_W'(lon));
        write_reg(REG_RADIUS, CFG_W'(radius));
    endtask

    // random points: half at or near the reference, most others anywhere, a few raw and mostly out of range
    task automatic random_points(int count);
        int mode;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            if (mode < 10) begin
                lat = cur_ref_lat;
                lon = cur_ref_lon;
            end else if (mode < 50) begin
                lat = LAT_W'(cur_ref_lat + $signed(LAT_W'($urandom_range(8000))) - 4000);
                lon = LON_W'(cur_ref_lon + $signed(LON_W'($urandom_range(8000))) - 4000);
            end else if (mode < 90) begin
                lat = LAT_W'($signed(LAT_W'($urandom_range(2 * 5898240))) - 5898240);
                lon = LON_W'($signed(LON_W'($urandom_range(2 * 11796480))) - 11796480);
            end else begin
                lat = LAT_W'($urandom);
                lon = LON_W'($urandom);
            end
            send_point(lat, lon, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed points against the reset reference and radius
        send_point(0, 0, 1'b0);
        send_point(5898240, 0, 1'b0);
        send_point(-5898240, 0, 1'b0);
        send_point(0, 11796480, 1'b0);
        send_point(0, -11796480, 1'b0);
        send_point(0, 3277, 1'b1);
        send_point(2949120, 5898240, 1'b0);
        send_point(-5898240, 11796480, 1'b1);
        send_point(0, 0, 1'b1);
        send_point(5898240, -11796480, 1'b1);
        send_point(24'sh7FFFFF, 25'sh0FFFFFF, 1'b0);
        send_point(24'sh800000, 25'sh1000000, 1'b0);
        send_point(5898240, 11796480, 1'b0);
        send_point(0, 6553, 1'b0);
        send_point(-1, -1, 1'b1);
        drain();

        // phase 1: reference at the far corner, widest radius, no idling
        set_reference(5898240, 11796480, 23'd5124096);
        write_reg(REG_UNUSED, 25'h1FFFFFF);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        random_points(PHASE_WORDS);
        drain();

        // phase 2: opposite corner, zero radius, sender idles
        set_reference(-5898240, -11796480, 23'd0);
        sender_idle_pct = 71;
        random_points(PHASE_WORDS);
        drain();

        // phase 3: random reference, ten km, receiver stalls
        set_reference(LAT_W'($signed(LAT_W'($urandom_range(2 * 5898240))) - 5898240),
                      LON_W'($signed(LON_W'($urandom_range(2 * 11796480))) - 11796480),
                      23'd2560);
        sender_idle_pct = 0;
        receiver_stall_pct = 71;
        random_points(PHASE_WORDS);
        drain();

        // phase 4: random reference and radius, both sides idle
        set_reference(LAT_W'($signed(LAT_W'($urandom_range(2 * 5898240))) - 5898240),
                      LON_W'($signed(LON_W'($urandom_range(2 * 11796480))) - 11796480),
                      DIST_W'($urandom_range(128000)));
        sender_idle_pct = 17;
        receiver_stall_pct = 17;
        random_points(PHASE_WORDS);
        drain();

        repeat (LATENCY) @(posedge aclk);
        $display("sent %0d points in %0d passes, %0d result words checked",
                 points_sent, passes_sent, words_checked);
        $display("covered four reference settings, radius 0 to full, idle and stall phases");
        if (fail_count == 0 && words_waiting == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
